// ===== hdl/det_pkg.sv =====
// ----------------------------------------------------------------------------
// det_pkg
// Shared constants and types for the dominance emptiness table.
// ----------------------------------------------------------------------------
package det_pkg;

  // Table geometry.
  localparam int ROWS    = 1024;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 10;
  localparam int ADDR_W  = $clog2(ROWS);
  localparam int IDX_W   = $clog2(ROWS + 1);          // Fenwick index 1..ROWS
  localparam int ENTRY_W = COL_W + 1;                 // column plus empty marker
  localparam int WIDE_W  = (ROW_W > IDX_W) ? ROW_W + 1 : IDX_W + 1;

  localparam logic [ENTRY_W-1:0] EMPTY_MARK = ENTRY_W'(1 << COL_W);

  // Item kinds carried on tuser.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } det_req_t;

  typedef struct packed {
    logic valid;
    logic found;
  } det_rsp_t;

endpackage

// ===== hdl/det_ram.sv =====
// ----------------------------------------------------------------------------
// det_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module det_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/det_walk.sv =====
// ----------------------------------------------------------------------------
// det_walk
// Fenwick walk sequencer: clearing pass, insert updates, prefix-min queries.
// ----------------------------------------------------------------------------
module det_walk (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  det_pkg::det_req_t req,
  output logic              idle,
  input  logic              out_free,
  output det_pkg::det_rsp_t rsp
);
  import det_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  clr_addr;
  logic [IDX_W-1:0]   idx;
  logic               issue;
  logic               p_vld;
  logic [ADDR_W-1:0]  p_addr;
  logic               mode;
  logic [COL_W-1:0]   col;
  logic [ENTRY_W-1:0] best;

  // RAM ports
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // Walk arithmetic
  logic [IDX_W-1:0]   low;
  logic [IDX_W:0]     ins_sum;
  logic [IDX_W-1:0]   qry_diff;
  logic               issue_more;
  logic [IDX_W-1:0]   idx_nxt;
  logic [ENTRY_W-1:0] best_upd;
  logic [WIDE_W-1:0]  row_wide;
  logic [WIDE_W-1:0]  row_sat;
  logic               row_out;
  logic [IDX_W-1:0]   idx_start;

  det_ram #(
    .DEPTH (ROWS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    low        = idx & (~idx + 1'b1);
    ins_sum    = {1'b0, idx} + {1'b0, low};
    qry_diff   = idx - low;
    if (mode == MODE_INSERT) begin
      issue_more = ins_sum <= (IDX_W + 1)'(ROWS);
      idx_nxt    = ins_sum[IDX_W-1:0];
    end else begin
      issue_more = qry_diff != '0;
      idx_nxt    = qry_diff;
    end
    best_upd   = (rd_data < best) ? rd_data : best;

    row_wide   = WIDE_W'(req.row);
    row_out    = row_wide >= WIDE_W'(ROWS);
    row_sat    = row_out ? WIDE_W'(ROWS - 1) : row_wide;
    idx_start  = IDX_W'(row_sat + 1'b1);

    rd_en      = (state == ST_WALK) && issue;
    rd_addr    = ADDR_W'(idx - 1'b1);

    wr_en      = 1'b0;
    wr_addr    = p_addr;
    wr_data    = ENTRY_W'(col);
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = EMPTY_MARK;
    end else if (state == ST_WALK && p_vld && mode == MODE_INSERT) begin
      wr_en   = ENTRY_W'(col) < rd_data;
    end
  end

  assign idle      = state == ST_IDLE;
  assign rsp.valid = (state == ST_DONE) && out_free;
  assign rsp.found = best <= ENTRY_W'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      issue    <= 1'b0;
      p_vld    <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start && !(req.mode == MODE_INSERT && row_out)) begin
            state <= ST_WALK;
            issue <= 1'b1;
            p_vld <= 1'b0;
            idx   <= idx_start;
            mode  <= req.mode;
            col   <= req.col;
            best  <= EMPTY_MARK;
          end
        end
        ST_WALK: begin
          // read of idx goes out while the previous entry is resolved
          p_vld <= issue;
          if (issue) begin
            p_addr <= rd_addr;
            idx    <= idx_nxt;
            issue  <= issue_more;
          end
          if (p_vld) begin
            best <= best_upd;
            if (!issue) begin
              state <= (mode == MODE_QUERY) ? ST_DONE : ST_IDLE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== hdl/dominance_emptiness_table.sv =====
// ----------------------------------------------------------------------------
// dominance_emptiness_table
// Point set with dominance emptiness queries over a prefix-min Fenwick tree.
// ----------------------------------------------------------------------------
// Keeps a set of grid points, empty after reset. A word with tuser = 0
// inserts point (row, col) and produces nothing; tuser = 1 queries and
// produces one word whose bit 0 is 1 when an active point has row <= the
// query row and col <= the query column. Row bounds at or beyond the table
// size search every row; inserts there are dropped. The set lives in one
// 1024 x 11 RAM holding, per Fenwick node, the smallest column inserted
// under it. After reset the block runs a clearing pass over all 1024
// entries, one entry a cycle, with s_tready low. Items are handled one at
// a time: an item walks its Fenwick path through the single RAM read port
// at one entry per cycle, the path length being at most log2(1024) + 1 = 11
// entries. A finished result sits in an output register, so the next item
// is taken while it waits; a query result only stalls the walker if that
// register is still full when the next query finishes.
// ----------------------------------------------------------------------------
module dominance_emptiness_table (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [9:0] row, [19:10] col, [23:20] zero
  input  logic        s_tuser,   // [0] mode: 0 insert, 1 query
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] found, [7:1] zero
);
  import det_pkg::*;

  det_req_t req;
  det_rsp_t rsp;
  logic     walk_idle;
  logic     in_fire;
  logic     out_free;
  logic     out_vld;
  logic     out_found;

  assign req.mode = s_tuser;
  assign req.row  = s_tdata[ROW_W-1:0];
  assign req.col  = s_tdata[ROW_W+COL_W-1:ROW_W];

  assign s_tready = walk_idle;
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !out_vld || m_tready;

  det_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire),
    .req      (req),
    .idle     (walk_idle),
    .out_free (out_free),
    .rsp      (rsp)
  );

  // Output register: loads when the walker retires a query.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (rsp.valid) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid) begin
      out_found <= rsp.found;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {7'b0, out_found};

  // A result is only retired into a free output slot.
  a_rsp_slot_free: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (!out_vld || m_tready))
    else $error("result retired into a full output register");

  // An accepted insert never produces a result in the next cycle.
  a_insert_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == MODE_INSERT) |=> !rsp.valid)
    else $error("insert produced a result");

  // An accepted query always busies the walker.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == MODE_QUERY) |=> !s_tready)
    else $error("walker idle right after a query");

endmodule

// ===== bench/dominance_emptiness_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dominance_emptiness_table_tb
// Self-checking bench for the dominance emptiness table.
// ----------------------------------------------------------------------------
// The bench first walks a short table of inserts and queries: the empty
// table, bounds one step short of a point, repeated points, the corner rows
// and columns. It then sends random traffic. A shadow copy of the point set,
// kept as the lowest column seen per row, predicts each query answer that
// the table leaves open. Expected flags are queued when the query word is
// accepted. Each result word is checked against the oldest one. The sender
// runs in random bursts and the receiver stalls on its own pattern. Once,
// the receiver holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module dominance_emptiness_table_tb;
  import det_pkg::*;

  localparam int RANDOM_WORDS = 900;
  localparam int HOLD_AFTER   = 300;   // input words before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 32;
  localparam int IDLE_LIMIT   = 4000;  // covers the clearing pass

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW} sink_style_e;

  // One row of the directed table; found is only used when known is set.
  typedef struct packed {
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             known;
    logic             found;
  } probe_t;

  localparam int N_DIRECTED = 22;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [9:0] row, [19:10] col, [23:20] zero
  logic        s_tuser = 1'b0; // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] found, [7:1] zero

  // Shadow point set: lowest active column per row, EMPTY_MARK if none.
  logic [ENTRY_W-1:0] lowest_col [ROWS];
  bit                 pending_found [$];

  int  errors      = 0;
  int  words_in    = 0;
  int  n_inserts   = 0;
  int  n_queries   = 0;
  int  n_hits      = 0;
  int  idle_cycles = 0;
  int  burst_left  = 1;
  bit  held_off    = 1'b0;
  bit  oldest;

  probe_t directed [N_DIRECTED] = '{
    '{MODE_QUERY,  10'd1023, 10'd1023, 1'b1, 1'b0},  // empty, widest bounds
    '{MODE_QUERY,  10'd0,    10'd0,    1'b1, 1'b0},  // empty, narrowest
    '{MODE_INSERT, 10'd512,  10'd700,  1'b0, 1'b0},
    '{MODE_QUERY,  10'd511,  10'd1023, 1'b1, 1'b0},  // row one short
    '{MODE_QUERY,  10'd512,  10'd699,  1'b1, 1'b0},  // col one short
    '{MODE_QUERY,  10'd512,  10'd700,  1'b1, 1'b1},  // bounds on the point
    '{MODE_INSERT, 10'd512,  10'd700,  1'b0, 1'b0},  // same point again
    '{MODE_QUERY,  10'd512,  10'd700,  1'b1, 1'b1},
    '{MODE_INSERT, 10'd512,  10'd900,  1'b0, 1'b0},  // higher col, same row
    '{MODE_QUERY,  10'd600,  10'd699,  1'b1, 1'b0},
    '{MODE_INSERT, 10'd1023, 10'd0,    1'b0, 1'b0},  // last row, col 0
    '{MODE_QUERY,  10'd1022, 10'd699,  1'b1, 1'b0},
    '{MODE_QUERY,  10'd1023, 10'd0,    1'b1, 1'b1},
    '{MODE_INSERT, 10'd0,    10'd1023, 1'b0, 1'b0},  // row 0, last col
    '{MODE_QUERY,  10'd0,    10'd1022, 1'b1, 1'b0},
    '{MODE_QUERY,  10'd0,    10'd1023, 1'b1, 1'b1},
    '{MODE_INSERT, 10'd700,  10'd5,    1'b0, 1'b0},
    '{MODE_QUERY,  10'd699,  10'd5,    1'b0, 1'b0},
    '{MODE_QUERY,  10'd700,  10'd5,    1'b1, 1'b1},
    '{MODE_INSERT, 10'd341,  10'd341,  1'b0, 1'b0},  // alternating bits
    '{MODE_QUERY,  10'd682,  10'd682,  1'b0, 1'b0},
    '{MODE_QUERY,  10'd1023, 10'd1023, 1'b1, 1'b1}
  };

  dominance_emptiness_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    for (int r = 0; r < ROWS; r++) lowest_col[r] = EMPTY_MARK;
  end

  function automatic void note_point(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    if ({1'b0, col} < lowest_col[row]) lowest_col[row] = {1'b0, col};
  endfunction

  // True when some active point sits at or below both bounds.
  function automatic bit dominated_point_exists(logic [ROW_W-1:0] row,
                                                logic [COL_W-1:0] col);
    for (int r = 0; r <= int'(row); r++)
      if (lowest_col[r] <= {1'b0, col}) return 1'b1;
    return 1'b0;
  endfunction

  // Offers one word, waits for it to be taken, then books the expectation.
  // Between bursts the valid may drop for a random gap.
  task automatic offer_word(logic mode, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            bit known, bit typed_found);
    bit want;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, col, row};
    do @(posedge clk); while (!s_tready);
    words_in++;
    if (mode == MODE_INSERT) begin
      note_point(row, col);
      n_inserts++;
    end else begin
      want = known ? typed_found : dominated_point_exists(row, col);
      pending_found = {pending_found, want};
      n_queries++;
      if (want) n_hits++;
    end
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stimulus: directed table, then random traffic, then drain and verdict.
  initial begin
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    do @(posedge clk); while (rst);
    foreach (directed[i])
      offer_word(directed[i].mode, directed[i].row, directed[i].col,
                 directed[i].known, directed[i].found);
    // Inserts lean to high rows and columns so queries answer both ways.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      mode = 1'($urandom_range(0, 1));
      if (mode == MODE_INSERT && $urandom_range(0, 3) != 0) begin
        row = ROW_W'($urandom_range(300, 1023));
        col = COL_W'($urandom_range(300, 1023));
      end else begin
        row = ROW_W'($urandom_range(0, 1023));
        col = COL_W'($urandom_range(0, 1023));
      end
      offer_word(mode, row, col, 1'b0, 1'b0);
    end
    s_tvalid <= 1'b0;
    while (pending_found.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d inserts and %0d queries, %0d answered found, %0d not found",
             n_inserts, n_queries, n_hits, n_queries - n_hits);
    $display("receiver long hold-off done: %0d", held_off);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: stretches of open, coin-flip or slow acceptance, plus one long
  // hold-off so the output register fills and the walker backs up.
  initial begin
    int          stretch;
    sink_style_e style;
    do @(posedge clk); while (rst);
    forever begin
      stretch = $urandom_range(10, 80);
      style   = sink_style_e'($urandom_range(0, 2));
      repeat (stretch) begin
        if (!held_off && words_in >= HOLD_AFTER) begin
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          held_off = 1'b1;
        end
        case (style)
          SINK_OPEN: m_tready <= 1'b1;
          SINK_COIN: m_tready <= 1'($urandom_range(0, 1));
          default:   m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Result check against the oldest waiting expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_found.size() == 0) begin
        $display("%0t: unexpected result word, found=%0b", $time, m_tdata[0]);
        errors++;
      end else begin
        oldest = pending_found.pop_front();
        if (m_tdata[0] !== oldest) begin
          $display("%0t: found mismatch, expected %0b, got %0b",
                   $time, oldest, m_tdata[0]);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no traffic for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending_found.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
